// File: rtl/core/rba_pkg.sv
// Shared types and constants for the reference-counted bank allocator.
package rba_pkg;

  // Fixed widths of the transaction fields on the ports.
  localparam int unsigned KEY_W    = 16;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned BANK_W   = 4;
  localparam int unsigned COUNT_W  = 16;

  // Request kinds.
  localparam logic KIND_CHECKOUT = 1'b0;
  localparam logic KIND_RETURN   = 1'b1;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_NEW       = 3'd0,
    ST_SHARED    = 3'd1,
    ST_NONE_FREE = 3'd2,
    ST_NOT_HELD  = 3'd3,
    ST_SATURATED = 3'd4
  } rba_status_t;

  // Update applied to one bank of the bank file.
  typedef struct packed {
    logic claim;
    logic incr;
    logic decr;
  } rba_upd_t;

endpackage

// File: rtl/core/refcounted_bank_allocator_top.sv
// Top level of the reference-counted bank allocator.
//
// Usage: a checkout transaction (kind 0) names an owner key. If a bank in use
// already holds that key, its reference count goes up and that bank is
// reported; otherwise the lowest free bank is claimed with count 1, or the
// request fails with "none free". A return transaction (kind 1) lowers the
// count of the bank holding the key and frees the bank when it reaches zero.
// Each request produces exactly one result transaction.
// An accepted request is held in the request register, decided, and written
// into the result register once that register is empty or being drained;
// the result is presented from there. The block takes one request per cycle
// while the receiver does not stall, set by the single pass of key compares,
// priority encoding and count update between the two registers.
// Reset (synchronous, active low) empties both registers and marks every bank
// free with a zero count. When the receiver stalls, the result holds and the
// request register fills; input ready then drops until the result is taken.
module refcounted_bank_allocator_top #(
  parameter int unsigned NUM_BANKS  = 16,
  parameter int unsigned KEY_BITS   = 16,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_kind,
  input  logic [rba_pkg::KEY_W-1:0]     in_owner_key,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rba_pkg::STATUS_W-1:0]  out_status,
  output logic [rba_pkg::BANK_W-1:0]    out_bank,
  output logic [rba_pkg::COUNT_W-1:0]   out_ref_count,
  output logic                          out_released
);

  import rba_pkg::*;

  localparam int unsigned IW = $clog2(NUM_BANKS);
  // Keys are compared in their low KEY_BITS bits; the port carries no more.
  localparam int unsigned KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  // Request register.
  logic          req_valid_r;
  logic          req_kind_r;
  logic [KW-1:0] req_key_r;

  // Result register.
  logic                  res_valid_r;
  rba_status_t           res_status_r;
  logic [BANK_W-1:0]     res_bank_r;
  logic [COUNT_W-1:0]    res_count_r;
  logic                  res_released_r;

  // Decision signals.
  logic                  advance;
  logic [NUM_BANKS-1:0]  in_use;
  logic [NUM_BANKS-1:0]  hit_vec;
  logic                  hit;
  logic [IW-1:0]         hit_idx;
  logic                  any_free;
  logic [IW-1:0]         free_idx;
  logic [COUNT_BITS-1:0] held_refs;
  logic [COUNT_BITS-1:0] dec_refs;
  rba_upd_t              upd;
  logic [IW-1:0]         upd_idx;
  rba_status_t           status_nxt;
  logic [IW-1:0]         bank_idx;
  logic [COUNT_BITS-1:0] count_nxt;
  logic                  released_nxt;
  logic [IW+BANK_W-1:0]  bank_ext;
  logic [COUNT_BITS+COUNT_W-1:0] count_ext;

  // The request moves on whenever the result register is empty or being drained.
  assign advance  = req_valid_r && (!res_valid_r || out_ready);
  assign in_ready = !req_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_ready) begin
      req_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_kind_r <= in_kind;
      req_key_r  <= in_owner_key[KW-1:0];
    end
  end

  rba_bank_file #(
    .NUM_BANKS  (NUM_BANKS),
    .KEY_BITS   (KW),
    .COUNT_BITS (COUNT_BITS)
  ) u_bank_file (
    .clk        (clk),
    .rst_n      (rst_n),
    .lookup_key (req_key_r),
    .sel_idx    (hit_idx),
    .upd_idx    (upd_idx),
    .upd        (upd),
    .in_use     (in_use),
    .hit_vec    (hit_vec),
    .sel_refs   (held_refs)
  );

  rba_prio_enc #(.N(NUM_BANKS)) u_hit_enc (
    .vec   (hit_vec),
    .found (hit),
    .idx   (hit_idx)
  );

  rba_prio_enc #(.N(NUM_BANKS)) u_free_enc (
    .vec   (~in_use),
    .found (any_free),
    .idx   (free_idx)
  );

  assign dec_refs = (held_refs == '0) ? '0 : (held_refs - CNT_ONE);

  always_comb begin
    upd          = '0;
    upd_idx      = hit_idx;
    status_nxt   = ST_NEW;
    bank_idx     = '0;
    count_nxt    = '0;
    released_nxt = 1'b0;
    if (req_kind_r == KIND_CHECKOUT) begin
      if (hit) begin
        bank_idx = hit_idx;
        if (held_refs == CNT_MAX) begin
          // Count pinned at its maximum; the bank is still reported.
          status_nxt = ST_SATURATED;
          count_nxt  = CNT_MAX;
        end else begin
          status_nxt = ST_SHARED;
          count_nxt  = held_refs + CNT_ONE;
          upd.incr   = advance;
        end
      end else if (any_free) begin
        status_nxt = ST_NEW;
        bank_idx   = free_idx;
        count_nxt  = CNT_ONE;
        upd_idx    = free_idx;
        upd.claim  = advance;
      end else begin
        status_nxt = ST_NONE_FREE;
      end
    end else begin
      if (hit) begin
        status_nxt   = ST_NEW;
        bank_idx     = hit_idx;
        count_nxt    = dec_refs;
        released_nxt = (dec_refs == '0);
        upd.decr     = advance;
      end else begin
        status_nxt = ST_NOT_HELD;
      end
    end
  end

  // Fit the bank index and count to the port widths.
  assign bank_ext  = {{BANK_W{1'b0}}, bank_idx};
  assign count_ext = {{COUNT_W{1'b0}}, count_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (advance) begin
      res_valid_r <= 1'b1;
    end else if (out_ready) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_status_r   <= status_nxt;
      res_bank_r     <= bank_ext[BANK_W-1:0];
      res_count_r    <= count_ext[COUNT_W-1:0];
      res_released_r <= released_nxt;
    end
  end

  assign out_valid     = res_valid_r;
  assign out_status    = res_status_r;
  assign out_bank      = res_bank_r;
  assign out_ref_count = res_count_r;
  assign out_released  = res_released_r;

endmodule

// File: rtl/core/rba_prio_enc.sv
// Lowest-index priority encoder over a request vector.
module rba_prio_enc #(
  parameter int unsigned N = 16
) (
  input  logic [N-1:0]         vec,
  output logic                 found,
  output logic [$clog2(N)-1:0] idx
);

  localparam int unsigned IW = $clog2(N);

  always_comb begin
    idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (vec[i]) begin
        idx = IW'(i);
      end
    end
  end

  assign found = |vec;

endmodule

// File: rtl/core/rba_bank_file.sv
// Bank state: in-use bits, owner keys and reference counts, with key lookup.
module rba_bank_file #(
  parameter int unsigned NUM_BANKS  = 16,
  parameter int unsigned KEY_BITS   = 16,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [KEY_BITS-1:0]          lookup_key,
  input  logic [$clog2(NUM_BANKS)-1:0] sel_idx,
  input  logic [$clog2(NUM_BANKS)-1:0] upd_idx,
  input  rba_pkg::rba_upd_t            upd,
  output logic [NUM_BANKS-1:0]         in_use,
  output logic [NUM_BANKS-1:0]         hit_vec,
  output logic [COUNT_BITS-1:0]        sel_refs
);

  import rba_pkg::*;

  localparam int unsigned IW = $clog2(NUM_BANKS);
  localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  logic [NUM_BANKS-1:0]  in_use_r;
  logic [NUM_BANKS-1:0]  in_use_nxt;
  logic [KEY_BITS-1:0]   owner_r  [NUM_BANKS];
  logic [COUNT_BITS-1:0] refs_r   [NUM_BANKS];
  logic [COUNT_BITS-1:0] refs_nxt [NUM_BANKS];

  // One comparator per bank; only banks in use can match.
  always_comb begin
    for (int b = 0; b < NUM_BANKS; b++) begin
      hit_vec[b] = in_use_r[b] && (owner_r[b] == lookup_key);
    end
  end

  assign in_use   = in_use_r;
  assign sel_refs = refs_r[sel_idx];

  always_comb begin
    for (int b = 0; b < NUM_BANKS; b++) begin
      in_use_nxt[b] = in_use_r[b];
      refs_nxt[b]   = refs_r[b];
      if (upd_idx == IW'(b)) begin
        if (upd.claim) begin
          in_use_nxt[b] = 1'b1;
          refs_nxt[b]   = CNT_ONE;
        end else if (upd.incr) begin
          if (refs_r[b] != CNT_MAX) begin
            refs_nxt[b] = refs_r[b] + CNT_ONE;
          end
        end else if (upd.decr) begin
          if (refs_r[b] != '0) begin
            refs_nxt[b] = refs_r[b] - CNT_ONE;
          end
          // The bank is freed once its count drops to zero.
          if (refs_r[b] <= CNT_ONE) begin
            in_use_nxt[b] = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r <= '0;
      for (int b = 0; b < NUM_BANKS; b++) begin
        refs_r[b] <= '0;
      end
    end else begin
      in_use_r <= in_use_nxt;
      for (int b = 0; b < NUM_BANKS; b++) begin
        refs_r[b] <= refs_nxt[b];
      end
    end
  end

  // Owner keys hold garbage until claimed; they are only compared while in use.
  always_ff @(posedge clk) begin
    if (upd.claim) begin
      owner_r[upd_idx] <= lookup_key;
    end
  end

endmodule

// File: test/tb_refcounted_bank_allocator_top.sv
// Self-checking testbench for the reference-counted bank allocator.
`timescale 1ns / 1ps

module tb_refcounted_bank_allocator_top;
  import rba_pkg::*;

  localparam int unsigned N_BANKS = 16;
  localparam logic [COUNT_W-1:0] CNT_MAX = {COUNT_W{1'b1}};
  localparam int unsigned POOL_SIZE = 24;
  localparam int unsigned RANDOM_ITEMS = 360;
  localparam int unsigned BURST_LEN = 20;
  localparam int unsigned HOLD_CYCLES = 400;

  // One request transaction waiting to be offered, with the idle cycles that
  // the sender inserts before it. Items marked fast run with no idling at all;
  // they are used for the back-to-back sharing burst.
  typedef struct {
    logic             kind;
    logic [KEY_W-1:0] key;
    int unsigned      gap;
    bit               fast;
  } req_t;

  // The result transaction predicted for one accepted request.
  typedef struct {
    rba_status_t        status;
    logic [BANK_W-1:0]  bank;
    logic [COUNT_W-1:0] cnt;
    logic               rel;
    bit                 fast;
  } grant_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_kind = KIND_CHECKOUT;
  logic [KEY_W-1:0] in_owner_key = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [BANK_W-1:0] out_bank;
  logic [COUNT_W-1:0] out_ref_count;
  logic out_released;

  // Our own view of the bank file, updated once per accepted request.
  logic               bank_busy [N_BANKS];
  logic [KEY_W-1:0]   bank_key  [N_BANKS];
  logic [COUNT_W-1:0] bank_cnt  [N_BANKS];

  req_t   request_queue[$];
  grant_t expected_grants[$];
  req_t   cur_req;

  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned hold_at = 0;
  int unsigned in_acc_cnt = 0;
  int unsigned out_acc_cnt = 0;
  int unsigned err_cnt = 0;
  int unsigned status_seen [5];
  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  refcounted_bank_allocator_top u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_owner_key  (in_owner_key),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_bank      (out_bank),
    .out_ref_count (out_ref_count),
    .out_released  (out_released)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Applies one request to the bank file and queues the result it must give.
  // A checkout first looks for an in-use bank that already holds the key;
  // the lowest match wins. Only if there is none does it claim the lowest
  // free bank. A shared bank whose count sits at the top keeps that count and
  // reports saturation. A return of a key that no bank holds changes nothing.
  function automatic void track_allocation(input req_t r);
    int     hit;
    int     slot;
    grant_t g;
    hit = -1;
    slot = -1;
    g.status = ST_NEW;
    g.bank = '0;
    g.cnt = '0;
    g.rel = 1'b0;
    g.fast = r.fast;
    for (int b = 0; b < N_BANKS; b++) begin
      if (hit < 0 && bank_busy[b] && bank_key[b] == r.key) hit = b;
      if (slot < 0 && !bank_busy[b]) slot = b;
    end
    if (r.kind == KIND_CHECKOUT) begin
      if (hit >= 0) begin
        if (bank_cnt[hit] == CNT_MAX) begin
          g.status = ST_SATURATED;
        end else begin
          bank_cnt[hit] = bank_cnt[hit] + 1'b1;
          g.status = ST_SHARED;
        end
        g.bank = BANK_W'(hit);
        g.cnt = bank_cnt[hit];
      end else if (slot < 0) begin
        g.status = ST_NONE_FREE;
      end else begin
        bank_busy[slot] = 1'b1;
        bank_key[slot] = r.key;
        bank_cnt[slot] = COUNT_W'(1);
        g.bank = BANK_W'(slot);
        g.cnt = COUNT_W'(1);
      end
    end else if (hit < 0) begin
      g.status = ST_NOT_HELD;
    end else begin
      // A successful return reports status "new" with the lowered count,
      // and frees the bank once nobody references it any more.
      if (bank_cnt[hit] != 0) bank_cnt[hit] = bank_cnt[hit] - 1'b1;
      if (bank_cnt[hit] == 0) begin
        bank_busy[hit] = 1'b0;
        g.rel = 1'b1;
      end
      g.bank = BANK_W'(hit);
      g.cnt = bank_cnt[hit];
    end
    expected_grants.push_back(g);
  endfunction

  function automatic void add_req(input logic kind, input logic [KEY_W-1:0] key,
                                  input int unsigned gap, input bit fast);
    req_t r;
    r.kind = kind;
    r.key = key;
    r.gap = gap;
    r.fast = fast;
    request_queue.push_back(r);
  endfunction

  function automatic void field_mismatch(input string name, input int unsigned want,
                                         input int unsigned got);
    $display("%0t: result %0d field %s mismatch: expected %0d, actual %0d",
             $time, out_acc_cnt, name, want, got);
    err_cnt++;
  endfunction

  // Sender. A slot opens when nothing is being offered or the current
  // transaction is taken at this edge. The idle cycles drawn for the next
  // item are burned first; valid then goes high and stays high, with the
  // payload steady, until the block accepts it.
  always @(posedge clk) begin
    req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready) begin
        track_allocation(cur_req);
        in_acc_cnt <= in_acc_cnt + 1;
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (request_queue.size() > 0) begin
          nxt = request_queue.pop_front();
          cur_req <= nxt;
          in_valid <= 1'b1;
          in_kind <= nxt.kind;
          in_owner_key <= nxt.key;
          gap_left <= (request_queue.size() > 0) ? request_queue[0].gap : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver. Each result transaction is checked against the oldest
  // prediction, then a fresh stall is drawn before the next one. Every third
  // stretch of fifty results runs with no stalls, and the back-to-back burst
  // never stalls so that it really runs at full rate.
  always @(posedge clk) begin
    grant_t      g;
    int unsigned stall_nxt;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else begin
      stall_nxt = (stall_left > 0) ? stall_left - 1 : 0;
      if (out_valid && out_ready) begin
        out_acc_cnt <= out_acc_cnt + 1;
        if (out_status < 5) status_seen[out_status]++;
        if (expected_grants.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status %0d bank %0d",
                   $time, out_status, out_bank);
          err_cnt++;
          stall_nxt = 0;
        end else begin
          g = expected_grants.pop_front();
          if (out_status !== g.status) field_mismatch("status", g.status, out_status);
          if (out_bank !== g.bank) field_mismatch("bank", g.bank, out_bank);
          if (out_ref_count !== g.cnt) field_mismatch("ref_count", g.cnt, out_ref_count);
          if (out_released !== g.rel) field_mismatch("released", g.rel, out_released);
          if (g.fast || (out_acc_cnt / 50) % 3 == 0) stall_nxt = 0;
          else stall_nxt = $urandom_range(0, 15);
        end
      end
      stall_left <= stall_nxt;
      out_ready <= (stall_nxt == 0) && (hold_left == 0);
    end
  end

  // Long receiver hold-off. Once the random phase is under way the result
  // side refuses everything for a long stretch while the sender keeps
  // offering, so the result and request registers fill and input ready
  // must drop until results drain again.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (!hold_done && hold_at != 0 && in_acc_cnt >= hold_at) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  initial begin
    int unsigned pick;
    int unsigned chk_pct;
    bit          calm;
    logic        kind;
    logic [KEY_W-1:0] key;

    for (int b = 0; b < N_BANKS; b++) begin
      bank_busy[b] = 1'b0;
      bank_key[b] = '0;
      bank_cnt[b] = '0;
    end
    for (int s = 0; s < 5; s++) status_seen[s] = 0;
    for (int p = 0; p < POOL_SIZE; p++) key_pool[p] = KEY_W'($urandom_range(0, 65535));

    // Directed part: return on an empty file, both key extremes, sharing,
    // release back to free, reuse of the lowest free bank, a full file that
    // refuses a new key but still shares a held one, and a return of a key
    // nobody holds.
    add_req(KIND_RETURN, 16'h1234, 0, 1'b0);
    add_req(KIND_CHECKOUT, 16'h0000, 0, 1'b0);
    add_req(KIND_CHECKOUT, 16'hFFFF, 2, 1'b0);
    add_req(KIND_CHECKOUT, 16'h0000, 0, 1'b0);
    add_req(KIND_RETURN, 16'h0000, 1, 1'b0);
    add_req(KIND_RETURN, 16'h0000, 0, 1'b0);
    add_req(KIND_CHECKOUT, 16'h5555, 0, 1'b0);
    for (int i = 0; i < 14; i++) add_req(KIND_CHECKOUT, KEY_W'(16'hA000 + i), i % 3, 1'b0);
    add_req(KIND_CHECKOUT, 16'hBEEF, 0, 1'b0);
    add_req(KIND_CHECKOUT, 16'hFFFF, 0, 1'b0);
    add_req(KIND_RETURN, 16'hBEEF, 0, 1'b0);
    add_req(KIND_RETURN, 16'hFFFF, 0, 1'b0);
    add_req(KIND_RETURN, 16'hFFFF, 0, 1'b0);
    add_req(KIND_RETURN, 16'h5555, 0, 1'b0);
    for (int i = 0; i < 14; i++) add_req(KIND_RETURN, KEY_W'(16'hA000 + i), 0, 1'b0);

    // Back-to-back burst: one key is shared many times with no idling on
    // either side, then returned down to zero so the bank is released.
    for (int unsigned i = 0; i < BURST_LEN; i++) add_req(KIND_CHECKOUT, 16'h8001, 0, 1'b1);
    for (int unsigned i = 0; i < BURST_LEN; i++) add_req(KIND_RETURN, 16'h8001, 0, 1'b1);
    hold_at = request_queue.size() + 60;

    // Random part: mostly checkouts and returns of a small key pool, larger
    // than the bank count so the file fills up, with blocks that lean toward
    // filling or draining. A tenth of the keys are arbitrary noise.
    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      calm = ((i / 40) % 3) == 1;
      chk_pct = ((i / 50) % 2 == 0) ? 70 : 35;
      kind = ($urandom_range(0, 99) < chk_pct) ? KIND_CHECKOUT : KIND_RETURN;
      pick = $urandom_range(0, 9);
      if (pick == 0) key = KEY_W'($urandom_range(0, 65535));
      else key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      add_req(kind, key, calm ? 0 : $urandom_range(0, 15), 1'b0);
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (request_queue.size() > 0 || in_valid) @(posedge clk);
    while (expected_grants.size() > 0) @(posedge clk);
    repeat (6) @(posedge clk);

    if (expected_grants.size() > 0) begin
      $display("%0t: %0d predicted results never arrived", $time, expected_grants.size());
      err_cnt++;
    end
    $display("Run covered %0d requests and %0d results, with a back-to-back sharing burst.",
             in_acc_cnt, out_acc_cnt);
    $display("Statuses seen: new %0d, shared %0d, none free %0d, not held %0d, saturated %0d.",
             status_seen[ST_NEW], status_seen[ST_SHARED], status_seen[ST_NONE_FREE],
             status_seen[ST_NOT_HELD], status_seen[ST_SATURATED]);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog. The slowest correct run is well under a tenth of this.
  initial begin
    #4_000_000;
    $display("Timeout: the run did not drain in time.");
    $display("DONE: errors detected");
    $finish;
  end

endmodule
